@@ rtl/ebd_pkg.sv @@
// ----------------------------------------------------------------------------
// ebd_pkg
// Shared widths, register indexes, reset values and helpers for the
// energy beat detector.
// ----------------------------------------------------------------------------
package ebd_pkg;

    localparam int SAMPLE_W   = 32;
    localparam int MAG_W      = 31;
    localparam int SUM_W      = 43;   // 4095 * (2^31 - 1) < 2^43
    localparam int LEN_W      = 12;
    localparam int DYN_W      = 8;
    localparam int STAT_W     = 18;
    localparam int COOL_W     = 16;
    localparam int FLOOR_W    = 32;
    localparam int PROD_W     = MAG_W + DYN_W;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 18;

    // Register indexes on the config port
    localparam logic [CFG_IDX_W-1:0] REG_DYN_THRESH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STAT_THRESH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COOLDOWN    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WIN_LEN     = 3'd3;

    localparam logic [DYN_W-1:0]   DYN_RESET    = 8'd45;
    localparam logic [COOL_W-1:0]  COOL_RESET   = 16'd2205;
    localparam int                 STATIC_SCALE = 10000;
    localparam logic [FLOOR_W-1:0] FLOOR_RESET  = 32'd5000000;  // 500 * 10000
    localparam int                 WIN_RESET    = 2000;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_UPDATE,
        ST_DIVIDE,
        ST_SCALE,
        ST_DECIDE
    } ebd_state_t;

    // Magnitude of a two's complement sample, saturated at 2^31-1.
    function automatic logic [MAG_W-1:0] sample_mag(input logic [SAMPLE_W-1:0] bits);
        logic [SAMPLE_W-1:0] neg;
        neg = ~bits + 32'd1;
        if (!bits[SAMPLE_W-1])
            return bits[MAG_W-1:0];
        else if (bits == 32'h8000_0000)
            return {MAG_W{1'b1}};
        else
            return neg[MAG_W-1:0];
    endfunction

endpackage

@@ rtl/ebd_ring.sv @@
// ----------------------------------------------------------------------------
// ebd_ring
// Single-port-write, single-port-read ring memory of sample magnitudes.
// Read data is registered.
// ----------------------------------------------------------------------------
module ebd_ring #(
    parameter int DEPTH = 2048,
    parameter int AW    = 11
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [AW-1:0]            wr_addr,
    input  logic [ebd_pkg::MAG_W-1:0] wr_data,
    input  logic                     rd_en,
    input  logic [AW-1:0]            rd_addr,
    output logic [ebd_pkg::MAG_W-1:0] rd_data
);
    import ebd_pkg::*;

    logic [MAG_W-1:0] mem [DEPTH];
    logic [MAG_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/ebd_div.sv @@
// ----------------------------------------------------------------------------
// ebd_div
// Restoring divider, one quotient bit per cycle. Expects a quotient below
// 2^31 (dividend < divisor * 2^31), so only 31 steps are run.
// ----------------------------------------------------------------------------
module ebd_div (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [ebd_pkg::SUM_W-1:0] dividend,
    input  logic [ebd_pkg::LEN_W-1:0] divisor,
    output logic                      done,
    output logic [ebd_pkg::MAG_W-1:0] quotient
);
    import ebd_pkg::*;

    localparam int CNT_W = $clog2(MAG_W + 1);

    logic [LEN_W-1:0] rem_reg, rem_next;
    logic [MAG_W-1:0] q_reg, q_next;
    logic [LEN_W-1:0] div_reg;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [LEN_W:0]   trial;
    logic [LEN_W:0]   diff;

    always_comb
    begin
        trial     = {rem_reg, q_reg[MAG_W-1]};
        diff      = trial - {1'b0, div_reg};
        rem_next  = rem_reg;
        q_next    = q_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = dividend[SUM_W-1:MAG_W];
            q_next    = dividend[MAG_W-1:0];
            cnt_next  = CNT_W'(MAG_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, div_reg})
            begin
                rem_next = diff[LEN_W-1:0];
                q_next   = {q_reg[MAG_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[LEN_W-1:0];
                q_next   = {q_reg[MAG_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        q_reg   <= q_next;
        if (start)
            div_reg <= divisor;
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

@@ rtl/energy_beat_detector_top.sv @@
// ----------------------------------------------------------------------------
// energy_beat_detector_top
// Flow: ring read, sum update, 31-step divide, threshold multiply, decision.
//   One sample at a time: no new sample is taken until the result of the
//   last one is loaded into the output register.
// Reset: a clearing pass writes zero to all MAX_WINDOW ring entries, one per
//   cycle, with in_ready low; a window_length write restarts the same pass.
// ----------------------------------------------------------------------------
module energy_beat_detector_top #(
    parameter int MAX_WINDOW     = 2048,
    parameter int CLASSIFY_DELAY = 256
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // sample channel
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic signed [ebd_pkg::SAMPLE_W-1:0] sample,
    // result channel
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic                           beat,
    output logic                           window_ready,
    output logic [ebd_pkg::MAG_W-1:0]      average_level,
    // config write channel
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [ebd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ebd_pkg::CFG_DATA_W-1:0] cfg_data
);
    import ebd_pkg::*;

    localparam int AW   = $clog2(MAX_WINDOW);
    // Compare width covering both the ring address and the window length
    localparam int CW   = ((AW > LEN_W) ? AW : LEN_W) + 1;
    localparam logic [LEN_W-1:0] LEN_RESET =
        (WIN_RESET > MAX_WINDOW) ? LEN_W'(MAX_WINDOW) : LEN_W'(WIN_RESET);
    localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_WINDOW - 1);

    // ------------------------------------------------------------------
    // Control state
    // ------------------------------------------------------------------
    ebd_state_t state_reg, state_next;

    logic [AW-1:0]      clr_addr_reg;
    logic [AW-1:0]      pos_reg;
    logic [SUM_W-1:0]   sum_reg;
    logic [COOL_W-1:0]  holdoff_reg;

    // Config registers
    logic [DYN_W-1:0]   dyn_reg;
    logic [FLOOR_W-1:0] floor_reg;      // magnitude floor setting * 10000
    logic [COOL_W-1:0]  cool_reg;
    logic [LEN_W-1:0]   len_reg;

    // Per-item datapath
    logic [MAG_W-1:0]   mag_reg;
    logic [PROD_W-1:0]  prod_reg;

    // Output register
    logic               out_valid_reg;
    logic               beat_reg;
    logic               wready_reg;
    logic [MAG_W-1:0]   avg_reg;

    // FSM outputs
    logic               in_fire;
    logic               rd_en;
    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic [MAG_W-1:0]   wr_data;
    logic               div_start;
    logic               out_load;

    logic               win_write;
    logic [LEN_W-1:0]   len_clamped;
    logic [MAG_W-1:0]   old_mag;
    logic [SUM_W-1:0]   sum_next;
    logic [MAG_W-1:0]   mean;
    logic               div_done;
    logic [CW-1:0]      pos_inc;

    logic [MAG_W+3:0]   mag_x10;
    logic               beat_now;
    logic [COOL_W-1:0]  hold_base;
    logic [COOL_W:0]    hold_inc;
    logic [COOL_W-1:0]  hold_next;
    logic               wready_now;

    assign cfg_ready = 1'b1;
    assign win_write = cfg_valid && (cfg_index == REG_WIN_LEN);

    // Window length: 0 is taken as 1, anything above the ring depth as the depth
    always_comb
    begin
        if (cfg_data[LEN_W-1:0] == '0)
            len_clamped = LEN_W'(1);
        else if (int'(cfg_data[LEN_W-1:0]) > MAX_WINDOW)
            len_clamped = LEN_W'(MAX_WINDOW);
        else
            len_clamped = cfg_data[LEN_W-1:0];
    end

    // ------------------------------------------------------------------
    // Ring memory and divider
    // ------------------------------------------------------------------
    ebd_ring #(
        .DEPTH (MAX_WINDOW),
        .AW    (AW)
    ) u_ring (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (pos_reg),
        .rd_data (old_mag)
    );

    ebd_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_next),
        .divisor  (len_reg),
        .done     (div_done),
        .quotient (mean)
    );

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        if (win_write)
            state_next = ST_CLEAR;
        else
        begin
            case (state_reg)
                ST_CLEAR:  if (clr_addr_reg == LAST_ADDR) state_next = ST_IDLE;
                ST_IDLE:   if (in_valid) state_next = ST_UPDATE;
                ST_UPDATE: state_next = ST_DIVIDE;
                ST_DIVIDE: if (div_done) state_next = ST_SCALE;
                ST_SCALE:  state_next = ST_DECIDE;
                ST_DECIDE: if (!out_valid_reg || out_ready) state_next = ST_IDLE;
                default:   state_next = ST_CLEAR;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // FSM outputs
    // ------------------------------------------------------------------
    always_comb
    begin
        in_ready  = 1'b0;
        rd_en     = 1'b0;
        wr_en     = 1'b0;
        wr_addr   = pos_reg;
        wr_data   = mag_reg;
        div_start = 1'b0;
        out_load  = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                wr_en   = 1'b1;
                wr_addr = clr_addr_reg;
                wr_data = '0;
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                rd_en    = in_valid;    // fetch the magnitude leaving the window
            end
            ST_UPDATE:
            begin
                wr_en     = 1'b1;       // new magnitude replaces the old slot
                div_start = 1'b1;
            end
            ST_DECIDE: out_load = !out_valid_reg || out_ready;
            default:   ;
        endcase
    end

    assign in_fire = in_valid && in_ready;

    // ------------------------------------------------------------------
    // Datapath
    // ------------------------------------------------------------------
    assign sum_next = sum_reg - SUM_W'(old_mag) + SUM_W'(mag_reg);
    assign pos_inc  = CW'(pos_reg) + CW'(1);

    assign mag_x10  = {1'b0, mag_reg, 3'b000} + {3'b000, mag_reg, 1'b0};

    // Beat needs all three: over the scaled mean, over the floor, cooldown done
    assign beat_now = (PROD_W'(mag_x10) > prod_reg)
                   && (FLOOR_W'(mag_reg) > floor_reg)
                   && (holdoff_reg >= cool_reg);
    assign hold_base  = beat_now ? '0 : holdoff_reg;
    assign wready_now = ({1'b0, hold_base} == (COOL_W + 1)'(CLASSIFY_DELAY));
    assign hold_inc   = {1'b0, hold_base} + (COOL_W + 1)'(1);
    assign hold_next  = (hold_inc > {1'b0, cool_reg}) ? cool_reg : hold_inc[COOL_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_addr_reg  <= '0;
            pos_reg       <= '0;
            sum_reg       <= '0;
            holdoff_reg   <= '0;
            dyn_reg       <= DYN_RESET;
            floor_reg     <= FLOOR_RESET;
            cool_reg      <= COOL_RESET;
            len_reg       <= LEN_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            // Window write restarts the clearing pass and the running sum
            if (win_write)
            begin
                clr_addr_reg <= '0;
                pos_reg      <= '0;
                sum_reg      <= '0;
            end
            else
            begin
                if (state_reg == ST_CLEAR)
                    clr_addr_reg <= clr_addr_reg + 1'b1;

                if (state_reg == ST_UPDATE)
                begin
                    sum_reg <= sum_next;
                    if (pos_inc >= CW'(len_reg))
                        pos_reg <= '0;
                    else
                        pos_reg <= pos_reg + 1'b1;
                end
            end

            if (out_load)
                holdoff_reg <= hold_next;

            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;

            // Config writes; window write wins over the item path
            if (cfg_valid)
            begin
                case (cfg_index)
                    REG_DYN_THRESH:  dyn_reg  <= cfg_data[DYN_W-1:0];
                    REG_STAT_THRESH: floor_reg <= FLOOR_W'(cfg_data[STAT_W-1:0])
                                                  * FLOOR_W'(STATIC_SCALE);
                    REG_COOLDOWN:    cool_reg <= cfg_data[COOL_W-1:0];
                    REG_WIN_LEN:     len_reg  <= len_clamped;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
            mag_reg <= sample_mag(sample);
        if (state_reg == ST_SCALE)
            prod_reg <= PROD_W'(mean) * PROD_W'(dyn_reg);
        if (out_load)
        begin
            beat_reg   <= beat_now;
            wready_reg <= wready_now;
            avg_reg    <= mean;
        end
    end

    assign out_valid     = out_valid_reg;
    assign beat          = beat_reg;
    assign window_ready  = wready_reg;
    assign average_level = avg_reg;

endmodule

@@ rtl/ebd_checker.sv @@
// ----------------------------------------------------------------------------
// ebd_checker
// Port-level checks for the energy beat detector, bound to the top level.
// ----------------------------------------------------------------------------
module ebd_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           in_valid,
    input logic                           in_ready,
    input logic [ebd_pkg::SAMPLE_W-1:0]   sample,
    input logic                           out_valid,
    input logic                           out_ready,
    input logic                           beat,
    input logic                           window_ready,
    input logic [ebd_pkg::MAG_W-1:0]      average_level,
    input logic                           cfg_valid,
    input logic                           cfg_ready,
    input logic [ebd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input logic [ebd_pkg::CFG_DATA_W-1:0] cfg_data
);
    import ebd_pkg::*;

    // A stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(beat)
            && $stable(window_ready) && $stable(average_level))
        else $error("result changed while stalled");

    // One item at a time: no transfer in the cycle after a transfer
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken while previous sample in progress");

    // A beat resets the holdoff count, which cannot then equal the delay
    a_beat_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(beat && window_ready))
        else $error("beat and window_ready together");

    // A window length write starts the clearing pass
    a_win_clear: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid && cfg_ready && (cfg_index == REG_WIN_LEN) |=> !in_ready)
        else $error("input open right after window length write");

endmodule

bind energy_beat_detector_top ebd_checker u_ebd_checker (.*);

@@ bench/ebd_onset_check.sv @@
// ----------------------------------------------------------------------------
// ebd_onset_check
// Watches the sample, result and config channels of the energy beat
// detector. It keeps its own copy of the detector state, predicts every
// result and compares each result transfer with the oldest prediction.
// ----------------------------------------------------------------------------
module ebd_onset_check #(
    parameter int MAX_WINDOW     = 2048,
    parameter int CLASSIFY_DELAY = 256
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    input  logic                             in_ready,
    input  logic [ebd_pkg::SAMPLE_W-1:0]     sample,
    input  logic                             out_valid,
    input  logic                             out_ready,
    input  logic                             beat,
    input  logic                             window_ready,
    input  logic [ebd_pkg::MAG_W-1:0]        average_level,
    input  logic                             cfg_valid,
    input  logic                             cfg_ready,
    input  logic [ebd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ebd_pkg::CFG_DATA_W-1:0]   cfg_data,
    output int                               mismatches,
    output int                               pending
);
    import ebd_pkg::*;

    typedef struct packed {
        logic             beat;
        logic             win_ready;
        logic [MAG_W-1:0] level;
    } onset_t;

    onset_t onsets_due[$];

    // register copies
    logic [DYN_W-1:0]    dyn_thr;
    logic [STAT_W-1:0]   stat_thr;
    logic [COOL_W-1:0]   cool_per;
    logic [LEN_W-1:0]    win_len;

    // detector state copies
    logic [SAMPLE_W-1:0] level_ring [MAX_WINDOW];
    logic [LEN_W-1:0]    wr_pos;
    logic [SUM_W-1:0]    lvl_sum;
    logic [MAG_W-1:0]    mean_lvl;
    logic [COOL_W-1:0]   hold_cnt;

    function automatic logic [MAG_W-1:0] abs_level(input logic [SAMPLE_W-1:0] bits);
        logic [SAMPLE_W-1:0] flipped;
        flipped = -bits;
        if (!bits[SAMPLE_W-1])
            return bits[MAG_W-1:0];
        if (bits == {1'b1, {(SAMPLE_W-1){1'b0}}})
            return {MAG_W{1'b1}};
        return flipped[MAG_W-1:0];
    endfunction

    // length is clamped to 1..MAX_WINDOW; ring, sum and position restart
    function automatic void restart_window(input logic [LEN_W-1:0] req);
        win_len = req;
        if (req == '0)
            win_len = LEN_W'(1);
        else if (req > MAX_WINDOW)
            win_len = LEN_W'(MAX_WINDOW);
        wr_pos  = '0;
        lvl_sum = '0;
        foreach (level_ring[i])
            level_ring[i] = '0;
    endfunction

    function automatic onset_t detect_onset(input logic [SAMPLE_W-1:0] bits);
        logic [MAG_W-1:0] mag;
        logic [MAG_W-1:0] dropped;
        logic [LEN_W-1:0] slot;
        logic [COOL_W:0]  next_hold;
        onset_t           r;
        mag  = abs_level(bits);
        slot = (wr_pos >= win_len) ? '0 : wr_pos;
        dropped = abs_level(level_ring[slot]);
        level_ring[slot] = bits;
        slot = slot + 1'b1;
        wr_pos = (slot >= win_len) ? '0 : slot;

        lvl_sum  = lvl_sum - dropped + mag;
        mean_lvl = MAG_W'(lvl_sum / win_len);

        r.beat = (64'(mag) * 64'd10 > 64'(mean_lvl) * 64'(dyn_thr))
              && (64'(mag) > 64'(stat_thr) * 64'(STATIC_SCALE))
              && (hold_cnt >= cool_per);
        if (r.beat)
            hold_cnt = '0;
        r.win_ready = (hold_cnt == CLASSIFY_DELAY);
        next_hold = hold_cnt + 1'b1;
        if (next_hold > cool_per)
            next_hold = cool_per;
        hold_cnt = next_hold[COOL_W-1:0];
        r.level  = mean_lvl;
        return r;
    endfunction

    function automatic void flag_error(input string what);
        mismatches++;
        if (mismatches <= 10)
            $display("[%0t] mismatch: %s", $time, what);
    endfunction

    always @(posedge clk or negedge rst_n) begin : watch
        onset_t want;
        if (!rst_n) begin
            dyn_thr  = DYN_RESET;
            stat_thr = STAT_W'(FLOOR_RESET / STATIC_SCALE);
            cool_per = COOL_RESET;
            mean_lvl = '0;
            hold_cnt = '0;
            restart_window(LEN_W'(WIN_RESET));
            onsets_due.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_DYN_THRESH:  dyn_thr  = cfg_data[DYN_W-1:0];
                    REG_STAT_THRESH: stat_thr = cfg_data[STAT_W-1:0];
                    REG_COOLDOWN:    cool_per = cfg_data[COOL_W-1:0];
                    REG_WIN_LEN:     restart_window(cfg_data[LEN_W-1:0]);
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
                onsets_due.push_back(detect_onset(sample));
            if (out_valid && out_ready) begin
                if (onsets_due.size() == 0) begin
                    flag_error($sformatf("result with nothing outstanding: beat %0b window_ready %0b average_level %0d",
                        beat, window_ready, average_level));
                end else begin
                    want = onsets_due.pop_front();
                    if (beat !== want.beat)
                        flag_error($sformatf("beat expected %0b got %0b", want.beat, beat));
                    if (window_ready !== want.win_ready)
                        flag_error($sformatf("window_ready expected %0b got %0b",
                            want.win_ready, window_ready));
                    if (average_level !== want.level)
                        flag_error($sformatf("average_level expected %0d got %0d",
                            want.level, average_level));
                end
            end
        end
        pending = onsets_due.size();
    end

endmodule

@@ bench/tb_energy_beat_detector_top.sv @@
// ----------------------------------------------------------------------------
// tb_energy_beat_detector_top
// Drives samples and register writes into the energy beat detector, applies
// random back-pressure on the result side and reports the verdict. All
// prediction and comparison lives in ebd_onset_check beside the block.
// ----------------------------------------------------------------------------
module tb_energy_beat_detector_top;
    import ebd_pkg::*;

    localparam int MAX_WINDOW     = 2048;
    localparam int CLASSIFY_DELAY = 256;
    // Longest legal silence: the ring clear after a window write, or the
    // squeeze below plus the divider latency. Several times over.
    localparam int STALL_LIMIT    = 20000;
    localparam int SQUEEZE_CYCLES = 600;
    localparam int TAIL_CYCLES    = 100;
    localparam int RANDOM_PHASES  = 8;

    // Sample stream shapes
    typedef enum {WAVE_RHYTHM, WAVE_NOISE, WAVE_MIXED} wave_t;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   in_valid  = 1'b0;
    logic                   in_ready;
    logic signed [SAMPLE_W-1:0] sample = '0;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    logic                   beat;
    logic                   window_ready;
    logic [MAG_W-1:0]       average_level;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    int mismatches;
    int pending;
    int quiet_cycles = 0;

    bit idle_en     = 1'b1;   // random gaps on both sides
    bit squeeze_req = 1'b0;   // ask the sink for one long hold-off
    int gap_pct     = 25;     // chance of a sender gap before a sample

    always #6 clk = ~clk;

    energy_beat_detector_top #(
        .MAX_WINDOW     (MAX_WINDOW),
        .CLASSIFY_DELAY (CLASSIFY_DELAY)
    ) dut (.*);

    ebd_onset_check #(
        .MAX_WINDOW     (MAX_WINDOW),
        .CLASSIFY_DELAY (CLASSIFY_DELAY)
    ) onset_check (.*);

    // ------------------------------------------------------------------
    // Watchdog: any transfer on any channel counts as progress.
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == STALL_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Result sink: ready and idle bursts of random length, and one long
    // squeeze on request so the block backs up and drops in_ready while
    // the sender keeps offering.
    // ------------------------------------------------------------------
    initial begin : result_sink
        forever begin
            @(negedge clk);
            if (squeeze_req) begin
                out_ready <= 1'b0;
                repeat (SQUEEZE_CYCLES) @(negedge clk);
                squeeze_req = 1'b0;
                out_ready <= 1'b1;
            end else if (idle_en && $urandom_range(0, 2) == 0) begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(negedge clk);
                out_ready <= 1'b1;
                repeat ($urandom_range(0, 60)) @(negedge clk);
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Sample side
    // ------------------------------------------------------------------

    // One sample transfer. Valid stays up across back-to-back samples; a
    // gap lowers it first, so it never drops and rises in one step.
    task automatic push_sample(input logic [SAMPLE_W-1:0] value);
        @(negedge clk);
        if (idle_en && $urandom_range(0, 99) < gap_pct) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge clk);
        end
        in_valid <= 1'b1;
        sample   <= value;
        do @(posedge clk); while (!in_ready);
    endtask

    // Drop valid and wait for every outstanding result. Each sample yields
    // exactly one result, so an empty queue means the block is idle.
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
    endtask

    // Register write; the value is cut to the data field width here.
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input int data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_W'(data);
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [SAMPLE_W-1:0] with_sign(input logic [SAMPLE_W-1:0] mag);
        logic [SAMPLE_W-1:0] v;
        v = mag;
        if ($urandom_range(0, 1))
            v = -v;
        return v;
    endfunction

    function automatic logic [SAMPLE_W-1:0] pick_sample(input wave_t shape);
        case (shape)
            // quiet floor with sparse loud hits: the usual beat pattern
            WAVE_RHYTHM:
                if ($urandom_range(0, 39) == 0)
                    return with_sign($urandom_range(20_000_000, 32'h7FFF_FFFF));
                else
                    return with_sign($urandom_range(0, 200_000));
            WAVE_NOISE:
                return $urandom;
            default:
                case ($urandom_range(0, 9))
                    0: case ($urandom_range(0, 5))
                           0: return 32'h0000_0000;
                           1: return 32'h0000_0001;
                           2: return 32'h7FFF_FFFF;
                           3: return 32'h8000_0000;
                           4: return 32'h8000_0001;
                           default: return 32'hFFFF_FFFF;
                       endcase
                    1, 2: return $urandom;
                    3, 4: return with_sign($urandom_range(5_000_000, 32'h7FFF_FFFF));
                    default: return with_sign($urandom_range(0, 300_000));
                endcase
        endcase
    endfunction

    // Random register settings between phases, extremes weighted in.
    task automatic retune();
        if ($urandom_range(0, 1))
            case ($urandom_range(0, 3))
                0: cfg_write(REG_DYN_THRESH, 0);
                1: cfg_write(REG_DYN_THRESH, 2**DYN_W - 1);
                default: cfg_write(REG_DYN_THRESH, $urandom_range(5, 80));
            endcase
        if ($urandom_range(0, 1))
            case ($urandom_range(0, 4))
                0: cfg_write(REG_STAT_THRESH, 0);
                1: cfg_write(REG_STAT_THRESH, 2**STAT_W - 1);
                2: cfg_write(REG_STAT_THRESH, $urandom_range(0, 2**STAT_W - 1));
                default: cfg_write(REG_STAT_THRESH, $urandom_range(0, 300));
            endcase
        if ($urandom_range(0, 1))
            case ($urandom_range(0, 5))
                0: cfg_write(REG_COOLDOWN, 0);
                1: cfg_write(REG_COOLDOWN, 2**COOL_W - 1);
                2: cfg_write(REG_COOLDOWN, $urandom_range(0, 2**COOL_W - 1));
                3, 4: cfg_write(REG_COOLDOWN, $urandom_range(CLASSIFY_DELAY, CLASSIFY_DELAY + 70));
                default: cfg_write(REG_COOLDOWN, $urandom_range(0, 40));
            endcase
        if ($urandom_range(0, 1))
            case ($urandom_range(0, 6))
                0: cfg_write(REG_WIN_LEN, 0);
                1: cfg_write(REG_WIN_LEN, 2**LEN_W - 1);
                2: cfg_write(REG_WIN_LEN, MAX_WINDOW);
                3: cfg_write(REG_WIN_LEN, 1);
                4: cfg_write(REG_WIN_LEN, $urandom_range(1, MAX_WINDOW));
                default: cfg_write(REG_WIN_LEN, $urandom_range(2, 40));
            endcase
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin : stimulus
        wave_t shape;
        int    count;

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset settings: magnitude extremes, incl. the most negative sample
        // whose magnitude saturates. Cooldown is far off, so no beats yet.
        push_sample(32'h0000_0000);
        push_sample(32'h7FFF_FFFF);
        push_sample(32'h8000_0000);
        push_sample(32'hFFFF_FFFF);
        push_sample(32'h8000_0001);
        push_sample(32'h0000_0001);
        settle();

        // Cooldown lowered below the running count: a beat may fire at once.
        // Zero thresholds let any nonzero magnitude through.
        cfg_write(REG_COOLDOWN, 0);
        cfg_write(REG_DYN_THRESH, 0);
        cfg_write(REG_STAT_THRESH, 0);
        push_sample(32'h0000_0000);
        push_sample(32'h0000_0005);
        push_sample(32'hFFFF_FFFB);
        push_sample(32'h8000_0000);
        settle();

        // Window length zero is taken as one.
        cfg_write(REG_WIN_LEN, 0);
        push_sample(32'h7FFF_FFFF);
        push_sample(32'h8000_0000);
        push_sample(32'h0000_0064);
        push_sample(32'hFFFF_FF9C);
        settle();

        // Top of every register; window above the ring size clamps.
        cfg_write(REG_DYN_THRESH, 2**DYN_W - 1);
        cfg_write(REG_STAT_THRESH, 2**STAT_W - 1);
        cfg_write(REG_COOLDOWN, 2**COOL_W - 1);
        cfg_write(REG_WIN_LEN, 2**LEN_W - 1);
        push_sample(32'h7FFF_FFFF);
        push_sample(32'h8000_0000);
        settle();

        // Indexes past the register list must change nothing.
        for (int i = REG_WIN_LEN + 1; i < 2**CFG_IDX_W; i++)
            cfg_write(CFG_IDX_W'(i), $urandom_range(0, 2**CFG_DATA_W - 1));
        repeat (3) push_sample($urandom);
        settle();

        // Beat-friendly setup: cooldown just above the classify delay so
        // window_ready has a chance to show up after each beat.
        cfg_write(REG_COOLDOWN, CLASSIFY_DELAY + 44);
        cfg_write(REG_DYN_THRESH, 30);
        cfg_write(REG_STAT_THRESH, 10);
        cfg_write(REG_WIN_LEN, 64);
        repeat (400) push_sample(pick_sample(WAVE_RHYTHM));
        settle();

        // Random phases; the second one carries the long result squeeze.
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            retune();
            shape   = wave_t'($urandom_range(0, 2));
            gap_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(10, 50);
            count   = $urandom_range(100, 180);
            if (p == 1)
                squeeze_req = 1'b1;
            repeat (count) push_sample(pick_sample(shape));
            settle();
        end

        // Closing phase at full rate on both sides.
        idle_en = 1'b0;
        retune();
        repeat (150) push_sample(pick_sample(WAVE_MIXED));
        settle();

        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
